// File: sv/tls_pkg.sv
package tls_pkg;

  localparam int PHASE_W = 9;
  localparam int BLINK_W = 7;
  localparam int CYCLE_W = 11;
  localparam int CROSS_W = 10;
  localparam int LAMP_W  = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [PHASE_W-1:0] PHASE_RST = 9'd372;
  localparam logic [BLINK_W-1:0] BLINK_RST = 7'd74;
  localparam logic [CYCLE_W-1:0] CYCLE_RST = 11'd371;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_TICKS = 2'd1;

  localparam logic [LAMP_W-1:0] LAMP_CAR_RED     = 6'b000001;
  localparam logic [LAMP_W-1:0] LAMP_CAR_YELLOW  = 6'b000010;
  localparam logic [LAMP_W-1:0] LAMP_CAR_GREEN   = 6'b000100;
  localparam logic [LAMP_W-1:0] LAMP_WALK_RED    = 6'b001000;
  localparam logic [LAMP_W-1:0] LAMP_WALK_YELLOW = 6'b010000;
  localparam logic [LAMP_W-1:0] LAMP_WALK_GREEN  = 6'b100000;

  typedef enum logic [2:0] {
    PH_RED    = 3'b001,
    PH_YELLOW = 3'b010,
    PH_GREEN  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [CYCLE_W-1:0] cycle_count;
    logic [CROSS_W-1:0] cross_count;
    logic               cross_active;
    phase_t             car_phase;
    logic [LAMP_W-1:0]  lamp_bits;
  } tls_state_t;

endpackage

// File: sv/tls_core.sv
module tls_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tick,
  input  logic                           button_pressed,
  input  logic [tls_pkg::PHASE_W-1:0]    phase_ticks,
  input  logic [tls_pkg::BLINK_W-1:0]    blink_ticks,
  output logic [tls_pkg::LAMP_W-1:0]     lamps_next
);
  import tls_pkg::*;

  tls_state_t state;
  tls_state_t state_next;

  logic [CYCLE_W-1:0] p1, p2, p3, p4;
  logic [CROSS_W-1:0] x1, b1, b2, b3, b4, b5, b5p1;
  logic               flash;

  assign p1   = {2'b00, phase_ticks};
  assign p2   = {1'b0, phase_ticks, 1'b0};
  assign p4   = {phase_ticks, 2'b00};
  assign p3   = p2 + p1;
  assign x1   = {1'b0, phase_ticks};
  assign b1   = {3'b000, blink_ticks};
  assign b2   = {2'b00, blink_ticks, 1'b0};
  assign b4   = {1'b0, blink_ticks, 2'b00};
  assign b3   = b2 + b1;
  assign b5   = b4 + b1;
  assign b5p1 = b5 + CROSS_W'(1);

  always_comb begin
    state_next = state;
    state_next.cycle_count = state.cycle_count + CYCLE_W'(1);
    state_next.cross_count = state.cross_count + CROSS_W'(1);
    flash = 1'b0;
    if (button_pressed) begin
      state_next.cross_active = 1'b1;
      state_next.cross_count  = '0;
    end
    if (state_next.cross_active) begin
      unique case (state.car_phase) inside
        PH_RED: begin
          state_next.lamp_bits = state.lamp_bits | LAMP_CAR_RED | LAMP_WALK_GREEN;
          if (state_next.cross_count == x1) begin
            state_next.cycle_count  = p4;
            state_next.cross_active = 1'b0;
            state_next.cross_count  = '0;
          end
        end
        PH_YELLOW, PH_GREEN: begin
          flash = (state_next.cross_count == b1) || (state_next.cross_count == b2) ||
                  (state_next.cross_count == b3) || (state_next.cross_count == b4) ||
                  (state_next.cross_count == b5);
          state_next.lamp_bits = LAMP_WALK_RED;
          if (flash) begin
            state_next.lamp_bits = LAMP_WALK_RED | LAMP_CAR_YELLOW | LAMP_WALK_YELLOW;
          end else if (state_next.cross_count == b5p1) begin
            state_next.lamp_bits    = '0;
            state_next.car_phase    = PH_YELLOW;
            state_next.cycle_count  = p3;
            state_next.cross_active = 1'b0;
            state_next.cross_count  = '0;
          end
        end
        default: begin
          state_next.lamp_bits = state.lamp_bits;
        end
      endcase
    end
    if (!state_next.cross_active) begin
      if (state_next.cycle_count == p1) begin
        state_next.lamp_bits = (state_next.lamp_bits & ~(LAMP_CAR_YELLOW | LAMP_WALK_YELLOW))
                               | LAMP_CAR_GREEN | LAMP_WALK_RED;
        state_next.car_phase = PH_GREEN;
      end else if (state_next.cycle_count == p2) begin
        state_next.lamp_bits = (state_next.lamp_bits & ~(LAMP_CAR_GREEN | LAMP_WALK_RED))
                               | LAMP_CAR_YELLOW | LAMP_WALK_YELLOW;
        state_next.car_phase = PH_YELLOW;
      end else if (state_next.cycle_count == p3) begin
        state_next.lamp_bits = (state_next.lamp_bits & ~(LAMP_CAR_YELLOW | LAMP_WALK_YELLOW))
                               | LAMP_CAR_RED | LAMP_WALK_GREEN;
        state_next.car_phase = PH_RED;
      end else if (state_next.cycle_count == p4) begin
        state_next.lamp_bits = (state_next.lamp_bits & ~(LAMP_CAR_RED | LAMP_WALK_GREEN))
                               | LAMP_CAR_YELLOW | LAMP_WALK_YELLOW;
        state_next.car_phase = PH_YELLOW;
        state_next.cycle_count = '0;
      end
    end else begin
      state_next.cycle_count = '0;
    end
  end

  assign lamps_next = state_next.lamp_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.cycle_count  <= CYCLE_RST;
      state.cross_count  <= '0;
      state.cross_active <= 1'b0;
      state.car_phase    <= PH_RED;
      state.lamp_bits    <= '0;
    end else if (tick) begin
      state <= state_next;
    end
  end

endmodule

// File: sv/tls_obuf.sv
module tls_obuf (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [tls_pkg::LAMP_W-1:0] push_data,
  output logic                       push_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tls_pkg::LAMP_W-1:0] out_data
);
  import tls_pkg::*;

  logic              skid_valid;
  logic [LAMP_W-1:0] skid_data;
  logic              out_fire;

  assign push_ready = !skid_valid;
  assign out_fire   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// File: sv/traffic_light_sequencer.sv
// Traffic light sequencer with pedestrian button.
// Slave stream: one beat per timer tick; s_tdata[0] is the button level.
// Master stream: one beat per accepted tick with the six lamp levels
// after that tick.
// Config channel: cfg_index 0 writes phase_ticks, 1 writes blink_ticks;
// other indexes are dropped. Write only while no beat is in flight.
// Output: each lamp beat is registered in the output buffer before it
// appears on m_tvalid. Throughput: one tick per cycle while s_tready is
// high, set by the compare-and-update step on the state registers.
// Stall: a two-entry output buffer holds results; s_tready drops while
// both entries are full and rises the cycle after m_tready takes a beat.
// Reset: lamps off, car phase red, normal mode, cycle counter at the
// reset phase period minus one, registers at 372 and 74.
module traffic_light_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] button_pressed
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [7:0]                      m_tdata,   // [0] car_red [1] car_yellow
                                                     // [2] car_green [3] walk_red
                                                     // [4] walk_yellow [5] walk_green
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tls_pkg::PHASE_W-1:0]     cfg_data
);
  import tls_pkg::*;

  logic [PHASE_W-1:0] phase_ticks;
  logic [BLINK_W-1:0] blink_ticks;
  logic               tick;
  logic [LAMP_W-1:0]  lamps_next;
  logic [LAMP_W-1:0]  lamps_out;

  assign cfg_ready = 1'b1;
  assign tick      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_RST;
      blink_ticks <= BLINK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PHASE_TICKS: phase_ticks <= cfg_data;
        REG_BLINK_TICKS: blink_ticks <= cfg_data[BLINK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tls_core u_core (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .button_pressed (s_tdata[0]),
    .phase_ticks    (phase_ticks),
    .blink_ticks    (blink_ticks),
    .lamps_next     (lamps_next)
  );

  tls_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .push       (tick),
    .push_data  (lamps_next),
    .push_ready (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (lamps_out)
  );

  assign m_tdata = {2'b00, lamps_out};

endmodule
